/* rtl/lkcp_pkg.sv */
// ----------------------------------------------------------------------------
// lkcp_pkg
// Shared types and constants of the line keyword command parser.
// ----------------------------------------------------------------------------
package lkcp_pkg;

  localparam logic [7:0] CharLf = 8'h0A;
  localparam logic [7:0] CharCr = 8'h0D;

  localparam int KeywordCount = 9;
  localparam int KeywordMax   = 6;
  localparam int CompareWin   = KeywordMax + 1;

  typedef enum logic [3:0] {
    CmdInit   = 4'd0,
    CmdIdle   = 4'd1,
    CmdCode   = 4'd2,
    CmdDocs   = 4'd3,
    CmdThink  = 4'd4,
    CmdSearch = 4'd5,
    CmdExper  = 4'd6,
    CmdError  = 4'd7,
    CmdStatus = 4'd8
  } cmd_e;

  typedef struct packed {
    logic valid;
    cmd_e code;
  } hit_t;

  // Keyword characters, zero padded to KeywordMax
  localparam logic [7:0] KeywordChar [KeywordCount][KeywordMax] = '{
    '{8'h49, 8'h4E, 8'h49, 8'h54, 8'h00, 8'h00},
    '{8'h49, 8'h44, 8'h4C, 8'h45, 8'h00, 8'h00},
    '{8'h43, 8'h4F, 8'h44, 8'h45, 8'h00, 8'h00},
    '{8'h44, 8'h4F, 8'h43, 8'h53, 8'h00, 8'h00},
    '{8'h54, 8'h48, 8'h49, 8'h4E, 8'h4B, 8'h00},
    '{8'h53, 8'h45, 8'h41, 8'h52, 8'h43, 8'h48},
    '{8'h45, 8'h58, 8'h50, 8'h45, 8'h52, 8'h00},
    '{8'h45, 8'h52, 8'h52, 8'h4F, 8'h52, 8'h00},
    '{8'h53, 8'h54, 8'h41, 8'h54, 8'h55, 8'h53}
  };

  localparam logic [2:0] KeywordLen [KeywordCount] = '{
    3'd4, 3'd4, 3'd4, 3'd4, 3'd5, 3'd6, 3'd5, 3'd5, 3'd6
  };

  localparam cmd_e KeywordCmd [KeywordCount] = '{
    CmdInit, CmdIdle, CmdCode, CmdDocs, CmdThink,
    CmdSearch, CmdExper, CmdError, CmdStatus
  };

endpackage

/* rtl/line_keyword_command_parser.sv */
// ----------------------------------------------------------------------------
// line_keyword_command_parser
// Collects received bytes into a text line and reports keyword commands.
//
//   channel   dir  tdata fields (low bit up)       tuser  tlast
//   s_axis    in   [7:0] rx_byte                   -      -
//   m_axis    out  [3:0] command_code, [7:4] zero  -      -
//
// One byte per cycle. A line feed that ends a keyword line puts its command
// code into the result register, or into the skid stage while the output is
// stalled. Reset empties the line. A stalled output parks one result in the
// skid stage; input stalls only when that stage is also full.
// ----------------------------------------------------------------------------
module line_keyword_command_parser #(
  parameter int LINE_CAPACITY = 15
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [3:0] command_code, [7:4] zero
);

  logic           accept;
  lkcp_pkg::hit_t hit;
  lkcp_pkg::cmd_e code;

  assign accept = s_axis_tvalid && s_axis_tready;

  lkcp_line_buffer #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_line (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (s_axis_tdata),
    .hit_o     (hit)
  );

  lkcp_out_skid u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hit_i       (hit),
    .space_o     (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_code_o  (code),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {4'b0000, code};

endmodule

/* rtl/lkcp_line_buffer.sv */
// ----------------------------------------------------------------------------
// lkcp_line_buffer
// Line length counter, stored head of the line and parallel keyword compare.
// ----------------------------------------------------------------------------
module lkcp_line_buffer #(
  parameter int LINE_CAPACITY = 15
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       rx_byte_i,
  output lkcp_pkg::hit_t   hit_o
);

  localparam int LenW = $clog2(LINE_CAPACITY + 1);
  localparam int Win  = (LINE_CAPACITY < lkcp_pkg::CompareWin) ?
                        LINE_CAPACITY : lkcp_pkg::CompareWin;
  localparam int IdxW = $clog2(Win);

  logic [LenW-1:0] len_q, len_d;
  logic [7:0]      store_q [Win];
  logic [7:0]      win_byte [lkcp_pkg::CompareWin];
  logic            is_cr, is_lf, is_char, wr_en;
  logic [lkcp_pkg::KeywordCount-1:0] kw_hit;

  assign is_cr   = (rx_byte_i == lkcp_pkg::CharCr);
  assign is_lf   = (rx_byte_i == lkcp_pkg::CharLf);
  assign is_char = accept_i && !is_cr && !is_lf;
  assign wr_en   = is_char && (len_q < LenW'(Win));

  for (genvar j = 0; j < lkcp_pkg::CompareWin; j++) begin : g_win
    if (j < Win) begin : g_held
      assign win_byte[j] = store_q[j];
    end else begin : g_none
      assign win_byte[j] = 8'h00;
    end
  end

  always_comb begin
    logic ok;
    logic [2:0] klen;
    for (int k = 0; k < lkcp_pkg::KeywordCount; k++) begin
      klen = lkcp_pkg::KeywordLen[k];
      ok   = (len_q == LenW'(klen)) || (win_byte[klen] == 8'h00);
      for (int j = 0; j < lkcp_pkg::KeywordMax; j++) begin
        if (3'(j) < klen) begin
          ok = ok && (LenW'(j) < len_q) &&
               (win_byte[j] == lkcp_pkg::KeywordChar[k][j]);
        end
      end
      kw_hit[k] = ok;
    end
  end

  always_comb begin
    hit_o.valid = 1'b0;
    hit_o.code  = lkcp_pkg::CmdInit;
    len_d       = len_q;
    if (accept_i && is_lf && (len_q != '0)) begin
      len_d = '0;
      for (int k = lkcp_pkg::KeywordCount - 1; k >= 0; k--) begin
        if (kw_hit[k]) begin
          hit_o.valid = 1'b1;
          hit_o.code  = lkcp_pkg::KeywordCmd[k];
        end
      end
    end else if (is_char) begin
      if (len_q < LenW'(LINE_CAPACITY)) begin
        len_d = len_q + LenW'(1);
      end else begin
        len_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[len_q[IdxW-1:0]] <= rx_byte_i;
    end
  end

endmodule

/* rtl/lkcp_out_skid.sv */
// ----------------------------------------------------------------------------
// lkcp_out_skid
// Result register with a skid stage; input runs while stalled until it fills.
// ----------------------------------------------------------------------------
module lkcp_out_skid (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lkcp_pkg::hit_t hit_i,
  output logic           space_o,
  output logic           out_valid_o,
  output lkcp_pkg::cmd_e out_code_o,
  input  logic           out_ready_i
);

  logic           out_valid_q, skid_valid_q;
  lkcp_pkg::cmd_e out_code_q, skid_code_q;
  logic           out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign space_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_code_o  = out_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || hit_i.valid;
      skid_valid_q <= 1'b0;
    end else if (hit_i.valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_code_q <= skid_valid_q ? skid_code_q : hit_i.code;
    end else if (hit_i.valid) begin
      skid_code_q <= hit_i.code;
    end
  end

endmodule
